// ----- hw/rtl/sdw_pkg.sv -----
// ----------------------------------------------------------------------------
// sdw_pkg
// Shared constants and helpers for the signed decimal digit writer.
// ----------------------------------------------------------------------------
package sdw_pkg;

	localparam int VALUE_W        = 28;
	localparam int MAG_W          = VALUE_W - 1;
	localparam int ADDR_W         = 4;
	localparam int DATA_W         = 4;
	localparam int NUM_DIGITS_DEF = 8;

	localparam logic [DATA_W-1:0] MINUS_CODE = 4'hA;

	// floor(n / 10) == (n * RECIP_M) >> RECIP_SHIFT holds for every n below 2^30.
	localparam int            RECIP_W     = 28;
	localparam logic [RECIP_W-1:0] RECIP_M = 28'd214748365;
	localparam int            RECIP_SHIFT = 31;
	localparam int            PROD_W      = MAG_W + RECIP_W;
	localparam int            QUO_W       = PROD_W - RECIP_SHIFT;

	// 10^n, wide enough for n up to eight.
	function automatic logic [MAG_W:0] pow_ten(input int n);
		logic [MAG_W:0] p;
		p = (MAG_W + 1)'(1);
		for (int k = 0; k < n; k++) begin
			p = (MAG_W + 1)'(p * 10);
		end
		return p;
	endfunction

endpackage

// ----- hw/rtl/signed_decimal_digit_writer.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_digit_writer
// Turns one signed number into a run of code-B digit register writes.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready, value) takes one signed number
// per beat. The output channel (out_valid/out_ready) returns one register
// write per beat: reg_addr, reg_data and last. The least significant digit
// goes to register NUM_DIGITS and each further digit one register lower; a
// negative number ends with a minus write one register below its top digit.
// Out-of-range values saturate to all nines that fit.
// Sequence: one number is handled at a time and in_ready is low meanwhile. After
// acceptance the S_SAT state saturates the magnitude; then each digit passes
// through the shared divide-by-ten unit (a registered reciprocal multiply in
// S_MUL, then the write beat in S_EMIT), and the minus write follows in S_SIGN.
// A stalled receiver holds the current write steady until out_ready rises.
// Reset returns the sequencer to idle with no write pending.
// ----------------------------------------------------------------------------
module signed_decimal_digit_writer #(
	parameter int NUM_DIGITS = sdw_pkg::NUM_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [sdw_pkg::VALUE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sdw_pkg::ADDR_W-1:0]         reg_addr,
	output logic [sdw_pkg::DATA_W-1:0]         reg_data,
	output logic                               last
);

	localparam logic [sdw_pkg::MAG_W:0] POS_MAX = sdw_pkg::pow_ten(NUM_DIGITS) - 1'b1;
	localparam logic [sdw_pkg::MAG_W:0] NEG_MAX = sdw_pkg::pow_ten(NUM_DIGITS - 1) - 1'b1;
	localparam logic                    NEG_OK  = (NUM_DIGITS > 1);
	localparam logic [sdw_pkg::ADDR_W-1:0] START_ADDR = sdw_pkg::ADDR_W'(NUM_DIGITS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SAT  = 5'b00010,
		S_MUL  = 5'b00100,
		S_EMIT = 5'b01000,
		S_SIGN = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [sdw_pkg::VALUE_W-1:0]   value_q;
	logic [sdw_pkg::MAG_W-1:0]     mag_q;
	logic                          neg_q;
	logic [sdw_pkg::ADDR_W-1:0]    addr_q;

	logic                          raw_neg;
	logic [sdw_pkg::VALUE_W-1:0]   mag_full;
	logic [sdw_pkg::VALUE_W-1:0]   mag_sat;
	logic                          neg_sat;
	logic [sdw_pkg::MAG_W-1:0]     quo;
	logic [3:0]                    rem;
	logic                          out_fire;

	sdw_div10 u_div10 (
		.clk      (clk),
		.start    (state_q == S_MUL),
		.dividend (mag_q),
		.quo      (quo),
		.rem      (rem)
	);

	// Magnitude and saturation of the held input.
	always_comb begin
		raw_neg  = value_q[sdw_pkg::VALUE_W-1];
		mag_full = raw_neg ? (sdw_pkg::VALUE_W'(0) - value_q) : value_q;
		neg_sat  = raw_neg;
		mag_sat  = mag_full;
		if (raw_neg) begin
			if (!NEG_OK) begin
				neg_sat = 1'b0;
				mag_sat = '0;
			end else if (mag_full > NEG_MAX) begin
				mag_sat = NEG_MAX;
			end
		end else if (mag_full > POS_MAX) begin
			mag_sat = POS_MAX;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT) || (state_q == S_SIGN);
	assign out_fire  = out_valid && out_ready;
	assign reg_addr  = addr_q;
	assign reg_data  = (state_q == S_SIGN) ? sdw_pkg::MINUS_CODE : rem;
	assign last      = (state_q == S_SIGN) || ((quo == '0) && !neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SAT;
				S_SAT:  state_q <= S_MUL;
				S_MUL:  state_q <= S_EMIT;
				S_EMIT: begin
					if (out_ready) begin
						if (quo != '0) begin
							state_q <= S_MUL;
						end else if (neg_q) begin
							state_q <= S_SIGN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SIGN: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_q <= value;
		end
		if (state_q == S_SAT) begin
			mag_q  <= mag_sat[sdw_pkg::MAG_W-1:0];
			neg_q  <= neg_sat;
			addr_q <= START_ADDR;
		end else if (state_q == S_EMIT && out_fire) begin
			mag_q  <= quo;
			addr_q <= addr_q - 1'b1;
		end
	end

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last |=> in_ready)
		else $error("block did not return to idle after the final beat");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("write offered right after a new number was taken");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (reg_addr >= 1) && (reg_addr <= START_ADDR))
		else $error("register address out of range");

	a_minus_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reg_data == sdw_pkg::MINUS_CODE) |-> last)
		else $error("minus write is not the final beat");

endmodule

// ----- hw/rtl/sdw_div10.sv -----
// ----------------------------------------------------------------------------
// sdw_div10
// Shared divide-by-ten unit: registered reciprocal multiply, then quotient
// and remainder taken from the held product and the held dividend.
// ----------------------------------------------------------------------------
module sdw_div10 (
	input  logic                        clk,
	input  logic                        start,
	input  logic [sdw_pkg::MAG_W-1:0]   dividend,
	output logic [sdw_pkg::MAG_W-1:0]   quo,
	output logic [3:0]                  rem
);

	logic [sdw_pkg::PROD_W-1:0] product_q;
	logic [sdw_pkg::MAG_W-1:0]  quo_x10;
	logic [sdw_pkg::MAG_W-1:0]  diff;

	// The dividend must stay unchanged between start and use of quo/rem.
	always_ff @(posedge clk) begin
		if (start) begin
			product_q <= sdw_pkg::PROD_W'(dividend) * sdw_pkg::PROD_W'(sdw_pkg::RECIP_M);
		end
	end

	assign quo     = sdw_pkg::MAG_W'(product_q[sdw_pkg::PROD_W-1:sdw_pkg::RECIP_SHIFT]);
	assign quo_x10 = {quo[sdw_pkg::MAG_W-4:0], 3'b000} + {quo[sdw_pkg::MAG_W-2:0], 1'b0};
	assign diff    = dividend - quo_x10;
	assign rem     = diff[3:0];

endmodule
